>>> rtl/core/stg_pkg.sv
// Shared types, constants and sine table function for the sine tone generator.
// Depends on nothing; used by stg_sine_rom and sine_tone_generator.
`default_nettype none

package stg_pkg;

    localparam int unsigned PHASE_STEP_WIDTH  = 32;
    localparam int unsigned TONE_FRAMES_WIDTH = 20;
    localparam int unsigned CFG_DATA_WIDTH    = 32;
    localparam int unsigned CFG_INDEX_WIDTH   = 1;
    localparam int unsigned SAMPLE_WIDTH      = 16;
    localparam int unsigned MAG_WIDTH         = 15;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t REG_PHASE_STEP  = 1'b0;
    localparam cfg_index_t REG_TONE_FRAMES = 1'b1;

    localparam logic [MAG_WIDTH-1:0] PEAK_MAG = 15'd32767;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // (2n)(2n+1) for n = 1..7
    localparam logic [7:0] TAYLOR_DIV [7] = '{8'd6, 8'd20, 8'd42, 8'd72,
                                              8'd110, 8'd156, 8'd210};

    typedef logic [MAG_WIDTH-1:0] mag_t;

    // Quarter-wave entry k: floor(32767 * sin(k*pi/2^(addr_bits+1))), Taylor series in Q30.
    function automatic mag_t sine_entry(input int unsigned k, input int unsigned addr_bits);
        logic [63:0]        angle;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        mag;
        angle = (64'(k) * HALF_PI_Q30) >> addr_bits;
        x2    = (angle * angle) >> 30;
        term  = angle;
        sum   = $signed(angle);
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n-1]);
            if ((n % 2) == 1)
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = '0;
        end
        mag = ($unsigned(sum) * 64'(PEAK_MAG)) >> 30;
        if (mag > 64'(PEAK_MAG))
        begin
            mag = 64'(PEAK_MAG);
        end
        return mag[MAG_WIDTH-1:0];
    endfunction

    // Side information traveling with a request through the table read.
    typedef struct packed {
        logic active;
        logic last;
        logic negate;
        logic peak;
    } lookup_info_t;

endpackage

`default_nettype wire

>>> rtl/core/sine_tone_generator.sv
// Sine tone generator: phase accumulator, quarter-wave ROM lookup, output register.
// Pipeline: ROM read with side-info register, then the output register.
// Throughput: 1 request per cycle without sink stalls; phase add feeds one ROM port.
// Reset: clears config, phase, frame count, playing, valid bits; not data or ROM.
// Depends on stg_pkg and stg_sine_rom.
`default_nettype none

module sine_tone_generator #(
    parameter int unsigned PHASE_BITS       = 32,
    parameter int unsigned TABLE_ADDR_BITS  = 10,
    parameter int unsigned FRAME_COUNT_BITS = 20
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration
    input  wire logic                                 cfg_we,
    input  wire logic [stg_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [stg_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    // request stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [7:0]                           s_tdata,   // [0] start_tone
    // result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [stg_pkg::SAMPLE_WIDTH-1:0]          m_tdata,   // [15:0] sample
    output logic                                      m_tlast,   // last_frame
    output logic                                      m_tuser    // [0] tone_active
);

    localparam int unsigned STEP_EXT_W  = (PHASE_BITS > stg_pkg::PHASE_STEP_WIDTH) ?
                                          PHASE_BITS : stg_pkg::PHASE_STEP_WIDTH;
    localparam int unsigned FRAME_EXT_W = (FRAME_COUNT_BITS > stg_pkg::TONE_FRAMES_WIDTH) ?
                                          FRAME_COUNT_BITS : stg_pkg::TONE_FRAMES_WIDTH;
    localparam int unsigned IDX_LSB     = PHASE_BITS - 2 - TABLE_ADDR_BITS;

    // configuration registers
    logic [PHASE_BITS-1:0]       phase_step_reg,  phase_step_next;
    logic [FRAME_COUNT_BITS-1:0] tone_frames_reg, tone_frames_next;
    logic [STEP_EXT_W-1:0]       step_ext;
    logic [FRAME_EXT_W-1:0]      frames_ext;

    // tone state
    logic [PHASE_BITS-1:0]       phase_reg, phase_next;
    logic [FRAME_COUNT_BITS-1:0] count_reg, count_next;
    logic                        playing_reg, playing_next;

    // handshake and pipeline control
    logic accept;
    logic en1;
    logic en2;
    logic v1_reg;
    logic v2_reg;

    // lookup stage
    logic [PHASE_BITS-1:0]       phase_eff;
    logic [FRAME_COUNT_BITS-1:0] count_eff;
    logic                        playing_eff;
    logic                        start;
    logic                        last;
    logic [1:0]                  quad;
    logic [TABLE_ADDR_BITS-1:0]  idx;
    logic [TABLE_ADDR_BITS-1:0]  rom_addr;
    logic [stg_pkg::MAG_WIDTH-1:0] rom_data;
    stg_pkg::lookup_info_t       info_next;
    stg_pkg::lookup_info_t       info1_reg;

    // output stage
    logic [stg_pkg::MAG_WIDTH-1:0]    mag;
    logic [stg_pkg::SAMPLE_WIDTH-1:0] mag_ext;
    logic [stg_pkg::SAMPLE_WIDTH-1:0] sample_next;
    logic [stg_pkg::SAMPLE_WIDTH-1:0] sample_reg;
    logic                             last2_reg;
    logic                             active2_reg;

    assign en2      = !v2_reg || m_tready;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && en1;
    assign start    = s_tdata[0];

    // configuration writes take effect only while no tone plays
    assign step_ext   = STEP_EXT_W'(cfg_data);
    assign frames_ext = FRAME_EXT_W'(cfg_data[stg_pkg::TONE_FRAMES_WIDTH-1:0]);

    always_comb
    begin
        phase_step_next  = phase_step_reg;
        tone_frames_next = tone_frames_reg;
        if (cfg_we && !playing_reg)
        begin
            unique case (cfg_index)
                stg_pkg::REG_PHASE_STEP:  phase_step_next  = step_ext[PHASE_BITS-1:0];
                stg_pkg::REG_TONE_FRAMES: tone_frames_next = frames_ext[FRAME_COUNT_BITS-1:0];
                default:                  ;
            endcase
        end
    end

    // tone sequencing
    always_comb
    begin
        if (start)
        begin
            phase_eff   = '0;
            count_eff   = '0;
            playing_eff = (tone_frames_reg != '0);
        end
        else
        begin
            phase_eff   = phase_reg;
            count_eff   = count_reg;
            playing_eff = playing_reg;
        end

        last = playing_eff && (count_eff == FRAME_COUNT_BITS'(tone_frames_reg - 1'b1));
        quad = phase_eff[PHASE_BITS-1 -: 2];
        idx  = phase_eff[IDX_LSB +: TABLE_ADDR_BITS];

        if (quad[0])
        begin
            rom_addr = TABLE_ADDR_BITS'(~idx + 1'b1);
        end
        else
        begin
            rom_addr = idx;
        end

        info_next.active = playing_eff;
        info_next.last   = last;
        info_next.negate = quad[1];
        info_next.peak   = quad[0] && (idx == '0);

        phase_next   = phase_reg;
        count_next   = count_reg;
        playing_next = playing_reg;
        if (accept)
        begin
            phase_next   = phase_eff;
            count_next   = count_eff;
            playing_next = playing_eff;
            if (playing_eff)
            begin
                phase_next = PHASE_BITS'(phase_eff + phase_step_reg);
                count_next = FRAME_COUNT_BITS'(count_eff + 1'b1);
                if (last)
                begin
                    playing_next = 1'b0;
                end
            end
        end
    end

    stg_sine_rom #(
        .ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .clk  (clk),
        .en   (en1),
        .addr (rom_addr),
        .data (rom_data)
    );

    // sign and peak fix-up after the ROM read; inactive frames give a zero sample
    always_comb
    begin
        mag     = info1_reg.peak ? stg_pkg::PEAK_MAG : rom_data;
        mag_ext = stg_pkg::SAMPLE_WIDTH'(mag);
        if (!info1_reg.active)
        begin
            sample_next = '0;
        end
        else if (info1_reg.negate)
        begin
            sample_next = stg_pkg::SAMPLE_WIDTH'(~mag_ext + 1'b1);
        end
        else
        begin
            sample_next = mag_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= '0;
            tone_frames_reg <= '0;
            phase_reg       <= '0;
            count_reg       <= '0;
            playing_reg     <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
        end
        else
        begin
            phase_step_reg  <= phase_step_next;
            tone_frames_reg <= tone_frames_next;
            phase_reg       <= phase_next;
            count_reg       <= count_next;
            playing_reg     <= playing_next;
            if (en1)
            begin
                v1_reg <= accept;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            info1_reg <= info_next;
        end
        if (en2)
        begin
            sample_reg  <= sample_next;
            last2_reg   <= info1_reg.last;
            active2_reg <= info1_reg.active;
        end
    end

    assign m_tvalid = v2_reg;
    assign m_tdata  = sample_reg;
    assign m_tlast  = last2_reg;
    assign m_tuser  = active2_reg;

endmodule

`default_nettype wire

>>> rtl/core/stg_sine_rom.sv
// Quarter-wave sine ROM with one registered read port.
// Depends on stg_pkg for the entry function.
`default_nettype none

module stg_sine_rom #(
    parameter int unsigned ADDR_BITS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [ADDR_BITS-1:0]  addr,
    output logic      [stg_pkg::MAG_WIDTH-1:0] data
);

    localparam int unsigned DEPTH = 1 << ADDR_BITS;

    typedef logic [stg_pkg::MAG_WIDTH-1:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k < DEPTH; k++)
        begin
            r[k] = stg_pkg::sine_entry(k, ADDR_BITS);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [stg_pkg::MAG_WIDTH-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= SINE_ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking bench for sine_tone_generator: directed table, then random tone runs.
// Keeps its own phase/frame predictor and quarter-wave table; needs stg_pkg and the RTL.
// Random source gaps and sink stalls, one quiet stretch with neither.

module tb_top;

    typedef struct packed {
        logic [15:0] sample;
        logic        last;
        logic        active;
    } tone_out_t;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        stg_pkg::cfg_index_t index;
        logic [31:0]         value;
        logic                start;
        logic                typed;
        tone_out_t           result;
    } row_t;

    localparam tone_out_t   SILENT           = '0;
    localparam int          ITEM_TARGET      = 1550;
    localparam int          MAX_REPORTS      = 100;
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam logic [15:0] FULL_SCALE       = 16'd32767;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [stg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = stg_pkg::REG_PHASE_STEP;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;      // [0] start_tone
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;             // [15:0] sample
    logic        m_tlast;             // last_frame
    logic        m_tuser;             // [0] tone_active
    logic        steady    = 1'b0;

    // predictor state
    logic [14:0] quarter_wave [1024];
    logic [31:0] phase_acc  = '0;
    logic [19:0] frame_idx  = '0;
    logic        tone_on    = 1'b0;
    logic [31:0] step_reg   = '0;
    logic [19:0] length_reg = '0;

    tone_out_t   pending_samples [$];
    row_t        plan [$];

    int items_sent    = 0;
    int samples_seen  = 0;
    int tones_ended   = 0;
    int regs_written  = 0;
    int regs_ignored  = 0;
    int error_count   = 0;

    sine_tone_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #6 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    // sin over a quarter turn, Taylor series in Q30
    function automatic logic [14:0] quarter_wave_entry(input int unsigned k);
        longint unsigned ang;
        longint unsigned sq;
        longint unsigned term;
        longint unsigned mag;
        longint          acc;
        ang  = (64'(k) * QUARTER_TURN_Q30) >> 10;
        sq   = (ang * ang) >> 30;
        term = ang;
        acc  = $signed(ang);
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * sq) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = acc - $signed(term);
            end
            else
            begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        mag = ($unsigned(acc) * 64'd32767) >> 30;
        if (mag > 64'd32767)
        begin
            mag = 64'd32767;
        end
        return 15'(mag);
    endfunction

    // quadrant mirror: bit 30 reflects the index, bit 31 negates
    function automatic logic [15:0] sine_sample(input logic [31:0] ph);
        logic [9:0]  idx;
        logic [15:0] mag;
        idx = ph[29:20];
        if (ph[30])
        begin
            mag = (idx == 10'd0) ? FULL_SCALE : {1'b0, quarter_wave[10'd0 - idx]};
        end
        else
        begin
            mag = {1'b0, quarter_wave[idx]};
        end
        return ph[31] ? 16'd0 - mag : mag;
    endfunction

    function automatic tone_out_t next_tone_sample(input logic start);
        tone_out_t r;
        logic      at_end;
        r = SILENT;
        if (start)
        begin
            phase_acc = '0;
            frame_idx = '0;
            tone_on   = (length_reg != 20'd0);
        end
        if (!tone_on)
        begin
            return r;
        end
        at_end    = (frame_idx == length_reg - 20'd1);
        r.sample  = sine_sample(phase_acc);
        r.last    = at_end;
        r.active  = 1'b1;
        phase_acc = phase_acc + step_reg;
        frame_idx = frame_idx + 20'd1;
        if (at_end)
        begin
            tone_on = 1'b0;
        end
        return r;
    endfunction

    function automatic row_t req_row(input logic start, input logic typed,
                                     input logic [15:0] smp, input logic lst,
                                     input logic act);
        row_t r;
        r        = '0;
        r.kind   = ROW_REQ;
        r.start  = start;
        r.typed  = typed;
        r.result = '{sample: smp, last: lst, active: act};
        return r;
    endfunction

    function automatic row_t cfg_row(input stg_pkg::cfg_index_t idx, input logic [31:0] value);
        row_t r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.index = idx;
        r.value = value;
        return r;
    endfunction

    task automatic send(input logic start, input logic typed, input tone_out_t typed_val);
        tone_out_t want;
        logic      quiet;
        quiet = (items_sent >= 500) && (items_sent < 800);
        steady <= quiet;
        if (!quiet && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, start};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        want = next_tone_sample(start);
        pending_samples.push_back(typed ? typed_val : want);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input stg_pkg::cfg_index_t idx, input logic [31:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        regs_written++;
        if (tone_on)
        begin
            regs_ignored++;
        end
        else if (idx == stg_pkg::REG_PHASE_STEP)
        begin
            step_reg = value;
        end
        else
        begin
            length_reg = value[19:0];
        end
    endtask

    task automatic run_phase();
        logic [31:0] step;
        logic [31:0] len;
        int          run;
        int          pick;
        case ($urandom_range(5))
            0: step = 32'h8000_0000;
            1: step = 32'd0;
            2: step = 32'(($urandom_range(32'd1_000_000) >> $urandom_range(20)));
            3: step = 32'((64'($urandom_range(20, 20000)) << 32) / 64'd44100);
            default: step = $urandom & 32'h7FFF_FFFF;
        endcase
        if ($urandom_range(3) == 0)
        begin
            write_reg(stg_pkg::REG_TONE_FRAMES, 32'($urandom_range(20'hF_FFFF)));
        end
        len = ($urandom_range(9) == 0) ? $urandom_range(64, 300) : $urandom_range(0, 24);
        write_reg(stg_pkg::REG_PHASE_STEP, step);
        write_reg(stg_pkg::REG_TONE_FRAMES, len);
        repeat ($urandom_range(2, 6))
        begin
            send(1'b1, 1'b0, SILENT);
            run  = (length_reg == 20'd0) ? 0 : int'(length_reg) - 1;
            pick = $urandom_range(9);
            if (pick == 0)
            begin
                run = $urandom_range(run);                  // cut short by next start
            end
            else if (pick == 1)
            begin
                run = run + $urandom_range(1, 4);           // silent tail
            end
            repeat (run) send(1'b0, 1'b0, SILENT);
            if (pick == 2)
            begin
                repeat ($urandom_range(1, 6)) send(1'($urandom_range(1)), 1'b0, SILENT);
            end
        end
        // sometimes leave the tone running so the next writes get dropped
        if ($urandom_range(6) != 0)
        begin
            while (tone_on)
            begin
                send(1'b0, 1'b0, SILENT);
            end
        end
    endtask

    always @(posedge clk)
    begin : check_result
        tone_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            samples_seen++;
            if (m_tlast)
            begin
                tones_ended++;
            end
            if (pending_samples.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected sample: got sample=%0d last=%b active=%b",
                             $time, $signed(m_tdata), m_tlast, m_tuser);
                end
            end
            else
            begin
                want = pending_samples.pop_front();
                if (m_tdata !== want.sample || m_tlast !== want.last
                    || m_tuser !== want.active)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch: expected %0d/%b/%b, got %0d/%b/%b",
                                 $time, $signed(want.sample), want.last, want.active,
                                 $signed(m_tdata), m_tlast, m_tuser);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 17);
    end

    initial
    begin
        for (int k = 0; k < 1024; k++)
        begin
            quarter_wave[k] = quarter_wave_entry(k);
        end

        // idle after reset, start with zero length
        plan.push_back(req_row(1'b0, 1'b1, 16'd0, 1'b0, 1'b0));
        plan.push_back(req_row(1'b1, 1'b1, 16'd0, 1'b0, 1'b0));
        // quarter-turn step hits every quadrant at index 0
        plan.push_back(cfg_row(stg_pkg::REG_PHASE_STEP, 32'h4000_0000));
        plan.push_back(cfg_row(stg_pkg::REG_TONE_FRAMES, 32'd5));
        plan.push_back(req_row(1'b1, 1'b1, 16'd0, 1'b0, 1'b1));
        plan.push_back(req_row(1'b0, 1'b1, 16'h7FFF, 1'b0, 1'b1));
        plan.push_back(req_row(1'b0, 1'b1, 16'd0, 1'b0, 1'b1));
        plan.push_back(req_row(1'b0, 1'b1, 16'h8001, 1'b0, 1'b1));
        plan.push_back(req_row(1'b0, 1'b1, 16'd0, 1'b1, 1'b1));
        plan.push_back(req_row(1'b0, 1'b1, 16'd0, 1'b0, 1'b0));
        // one-frame tone
        plan.push_back(cfg_row(stg_pkg::REG_TONE_FRAMES, 32'd1));
        plan.push_back(req_row(1'b1, 1'b1, 16'd0, 1'b1, 1'b1));
        plan.push_back(req_row(1'b0, 1'b1, 16'd0, 1'b0, 1'b0));
        // half-turn step, phase wraps back to zero
        plan.push_back(cfg_row(stg_pkg::REG_PHASE_STEP, 32'h8000_0000));
        plan.push_back(cfg_row(stg_pkg::REG_TONE_FRAMES, 32'd3));
        plan.push_back(req_row(1'b1, 1'b1, 16'd0, 1'b0, 1'b1));
        plan.push_back(req_row(1'b0, 1'b1, 16'd0, 1'b0, 1'b1));
        plan.push_back(req_row(1'b0, 1'b1, 16'd0, 1'b1, 1'b1));
        // restart mid-tone, then writes that land during the tone
        plan.push_back(cfg_row(stg_pkg::REG_PHASE_STEP, 32'h0123_4567));
        plan.push_back(cfg_row(stg_pkg::REG_TONE_FRAMES, 32'd6));
        plan.push_back(req_row(1'b1, 1'b0, 16'd0, 1'b0, 1'b0));
        plan.push_back(req_row(1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
        plan.push_back(req_row(1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
        plan.push_back(req_row(1'b1, 1'b0, 16'd0, 1'b0, 1'b0));
        plan.push_back(cfg_row(stg_pkg::REG_PHASE_STEP, 32'h7FFF_FFFF));
        plan.push_back(cfg_row(stg_pkg::REG_TONE_FRAMES, 32'd2));
        for (int i = 0; i < 5; i++)
        begin
            plan.push_back(req_row(1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
        end
        // zero step holds phase at zero
        plan.push_back(cfg_row(stg_pkg::REG_PHASE_STEP, 32'd0));
        plan.push_back(cfg_row(stg_pkg::REG_TONE_FRAMES, 32'd4));
        plan.push_back(req_row(1'b1, 1'b0, 16'd0, 1'b0, 1'b0));
        plan.push_back(req_row(1'b0, 1'b0, 16'd0, 1'b0, 1'b0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                write_reg(plan[i].index, plan[i].value);
            end
            else
            begin
                send(plan[i].start, plan[i].typed, plan[i].result);
            end
        end

        while (items_sent < ITEM_TARGET - 60)
        begin
            run_phase();
        end

        // longest tone: left running at the end
        while (tone_on)
        begin
            send(1'b0, 1'b0, SILENT);
        end
        write_reg(stg_pkg::REG_TONE_FRAMES, 32'h000F_FFFF);
        write_reg(stg_pkg::REG_PHASE_STEP, $urandom & 32'h7FFF_FFFF);
        send(1'b1, 1'b0, SILENT);
        repeat (60) send(1'($urandom_range(19) == 0), 1'b0, SILENT);

        drain();
        repeat (6) @(posedge clk);

        $display("Sent %0d requests, checked %0d samples, %0d tones reached their last frame",
                 items_sent, samples_seen, tones_ended);
        $display("%0d register writes, %0d of them dropped during a tone; %0d mismatches",
                 regs_written, regs_ignored, error_count);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/stg_pkg.sv
rtl/core/stg_sine_rom.sv
rtl/core/sine_tone_generator.sv
sim/tb_top.sv
